[rtl/gmbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmbd_pkg
// Shared types, constants and tables of the multi-bin Goertzel detector.
// ----------------------------------------------------------------------------
package gmbd_pkg;

    localparam int MAX_TARGETS  = 4;
    localparam int MAX_BLOCK    = 1024;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ST_W         = 48;
    localparam int COEF_W       = 18;
    localparam int MUL_AW       = 53;
    localparam int MUL_BW       = 19;
    localparam int MUL_PW       = 56;
    localparam int MUL_LO_W     = 26;
    localparam int Z_W          = 21;
    localparam int CORDIC_STEPS = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int PI_Q16       = 205887;
    localparam int PHASE_MAX    = 25736;
    localparam int MAG_MAX      = 33554432;
    localparam int INV_GAIN_Q16 = 39797;

    localparam logic [2:0] CFG_BLOCK_LENGTH = 3'd0;
    localparam logic [2:0] CFG_TARGET_COUNT = 3'd1;
    localparam logic [2:0] CFG_COEFF_0      = 3'd2;
    localparam logic [2:0] CFG_COEFF_1      = 3'd3;
    localparam logic [2:0] CFG_COEFF_2      = 3'd4;
    localparam logic [2:0] CFG_COEFF_3      = 3'd5;

    typedef logic [1:0] tidx_t;

    typedef struct packed {
        logic [10:0]                      block_length;
        logic [2:0]                       target_count;
        logic [MAX_TARGETS-1:0][35:0]     coeff;
    } cfg_t;

    typedef struct packed {
        tidx_t                  idx;
        logic signed [ST_W-1:0] s1;
        logic signed [ST_W-1:0] s2;
        logic                   last;
    } entry_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_SUM
    } mul_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_WAIT,
        F_END,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RE,
        B_RE_W,
        B_IM,
        B_IM_W,
        B_PRE,
        B_ROT,
        B_MAG,
        B_MAG_W,
        B_FIN
    } back_state_t;

    function automatic logic [16:0] atan_q16(input logic [3:0] i);
        logic [16:0] r;
        begin
            case (i)
                4'd0:    r = 17'd51472;
                4'd1:    r = 17'd30386;
                4'd2:    r = 17'd16055;
                4'd3:    r = 17'd8150;
                4'd4:    r = 17'd4091;
                4'd5:    r = 17'd2047;
                4'd6:    r = 17'd1024;
                4'd7:    r = 17'd512;
                4'd8:    r = 17'd256;
                4'd9:    r = 17'd128;
                4'd10:   r = 17'd64;
                4'd11:   r = 17'd32;
                4'd12:   r = 17'd16;
                4'd13:   r = 17'd8;
                4'd14:   r = 17'd4;
                4'd15:   r = 17'd2;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/goertzel_multi_bin_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// goertzel_multi_bin_detector
// Four-bin Goertzel tone detector with CORDIC magnitude and phase per bin.
// ----------------------------------------------------------------------------
// Per sample, the recursion unit's single multiplier (low and high partial
// products, rounding sum, plus issue and write-back) serves the four bins in
// turn. At block end the active bins are queued, one per cycle while the
// queue has room; the result unit (per bin: two rounding multiplies, sixteen
// CORDIC steps, gain multiply) runs concurrently with the next block.
// Configuration must be written only while idle, unchecked; cfg_ready = 1.
// ----------------------------------------------------------------------------
module goertzel_multi_bin_detector (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [2:0]                               cfg_index,
    input  wire logic [35:0]                              cfg_data,
    input  wire logic                                     sample_valid,
    output logic                                          sample_stall,
    input  wire logic signed [gmbd_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic                                          result_valid,
    input  wire logic                                     result_stall,
    output logic [1:0]                                    target_index,
    output logic [25:0]                                   magnitude,
    output logic signed [15:0]                            phase,
    output logic                                          last_of_block
);
    gmbd_pkg::cfg_t   cfg_reg;
    gmbd_pkg::entry_t push_data;
    gmbd_pkg::entry_t pop_data;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_length <= 11'd256;
            cfg_reg.target_count <= 3'd0;
            cfg_reg.coeff        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gmbd_pkg::CFG_BLOCK_LENGTH: cfg_reg.block_length <= cfg_data[10:0];
                gmbd_pkg::CFG_TARGET_COUNT: cfg_reg.target_count <= cfg_data[2:0];
                gmbd_pkg::CFG_COEFF_0:      cfg_reg.coeff[0]     <= cfg_data;
                gmbd_pkg::CFG_COEFF_1:      cfg_reg.coeff[1]     <= cfg_data;
                gmbd_pkg::CFG_COEFF_2:      cfg_reg.coeff[2]     <= cfg_data;
                gmbd_pkg::CFG_COEFF_3:      cfg_reg.coeff[3]     <= cfg_data;
                default:                    cfg_reg.target_count <= cfg_reg.target_count;
            endcase
        end
    end

    gmbd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_data    (push_data),
        .fifo_full    (fifo_full)
    );

    gmbd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .full    (fifo_full),
        .pop     (pop),
        .rd_data (pop_data),
        .empty   (fifo_empty)
    );

    gmbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .fifo_empty    (fifo_empty),
        .fifo_data     (pop_data),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .target_index  (target_index),
        .magnitude     (magnitude),
        .phase         (phase),
        .last_of_block (last_of_block)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && fifo_empty))
        else $error("queue read while empty");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (phase <= 16'sd25736 && phase >= -16'sd25736))
        else $error("phase out of range");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (magnitude <= 26'd33554432))
        else $error("magnitude out of range");
endmodule
`default_nettype wire

[rtl/gmbd_mulq16.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmbd_mulq16
// Multi-cycle signed multiply with Q16 round-half-up: floor((a*b + 2^15)/2^16).
// ----------------------------------------------------------------------------
module gmbd_mulq16 (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [gmbd_pkg::MUL_AW-1:0]   a,
    input  wire logic signed [gmbd_pkg::MUL_BW-1:0]   b,
    output logic                                      done,
    output logic signed [gmbd_pkg::MUL_PW-1:0]        p
);
    localparam int LW = gmbd_pkg::MUL_LO_W;
    localparam int PPW = LW + 1 + gmbd_pkg::MUL_BW;
    localparam int FW = gmbd_pkg::MUL_AW + gmbd_pkg::MUL_BW;

    gmbd_pkg::mul_state_t state_reg, state_next;
    logic signed [gmbd_pkg::MUL_AW-1:0] a_reg;
    logic signed [gmbd_pkg::MUL_BW-1:0] b_reg;
    logic signed [PPW-1:0]              plo_reg;
    logic signed [PPW-1:0]              phi_reg;
    logic signed [gmbd_pkg::MUL_PW-1:0] p_reg;
    logic                               done_reg;
    logic signed [FW-1:0]               full_w;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmbd_pkg::M_IDLE: if (start) state_next = gmbd_pkg::M_LO;
            gmbd_pkg::M_LO:   state_next = gmbd_pkg::M_HI;
            gmbd_pkg::M_HI:   state_next = gmbd_pkg::M_SUM;
            gmbd_pkg::M_SUM:  state_next = gmbd_pkg::M_IDLE;
            default:          state_next = gmbd_pkg::M_IDLE;
        endcase
    end

    assign full_w = ($signed({{(FW-PPW){phi_reg[PPW-1]}}, phi_reg}) <<< LW)
                  + $signed({{(FW-PPW){plo_reg[PPW-1]}}, plo_reg})
                  + $signed(FW'(32768));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmbd_pkg::M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == gmbd_pkg::M_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gmbd_pkg::M_IDLE && start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (state_reg == gmbd_pkg::M_LO)
            plo_reg <= $signed({1'b0, a_reg[LW-1:0]}) * b_reg;
        if (state_reg == gmbd_pkg::M_HI)
            phi_reg <= PPW'($signed(a_reg[gmbd_pkg::MUL_AW-1:LW]) * b_reg);
        if (state_reg == gmbd_pkg::M_SUM)
            p_reg <= full_w[FW-1:16];
    end

    assign done = done_reg;
    assign p    = p_reg;
endmodule
`default_nettype wire

[rtl/gmbd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmbd_fifo
// Short queue of block-end snapshots between recursion front and CORDIC back.
// ----------------------------------------------------------------------------
module gmbd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire gmbd_pkg::entry_t  wr_data,
    output logic                   full,
    input  wire logic              pop,
    output gmbd_pkg::entry_t       rd_data,
    output logic                   empty
);
    gmbd_pkg::entry_t mem_reg [gmbd_pkg::FIFO_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    assign full    = (count_reg == 3'(gmbd_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == 3'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push && !full) - 3'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= wr_data;
    end
endmodule
`default_nettype wire

[rtl/gmbd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmbd_front
// Sample intake and the four Goertzel recursions; snapshots bins at block end.
// ----------------------------------------------------------------------------
module gmbd_front (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire gmbd_pkg::cfg_t                           cfg,
    input  wire logic                                     sample_valid,
    output logic                                          sample_stall,
    input  wire logic signed [gmbd_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic                                          push,
    output gmbd_pkg::entry_t                              push_data,
    input  wire logic                                     fifo_full
);
    localparam int SW = gmbd_pkg::ST_W;
    localparam int XW = SW + 10;
    localparam logic signed [XW-1:0] ST_MAX = (XW'(1) <<< (SW - 1)) - XW'(1);
    localparam logic signed [XW-1:0] ST_MIN = -ST_MAX - XW'(1);

    gmbd_pkg::front_state_t state_reg, state_next;
    logic [1:0]  k_reg;
    logic [10:0] cnt_reg;
    logic signed [gmbd_pkg::SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SW-1:0] s1_reg [gmbd_pkg::MAX_TARGETS];
    logic signed [SW-1:0] s2_reg [gmbd_pkg::MAX_TARGETS];

    logic [10:0] len_eff;
    logic [2:0]  tc_eff;
    logic [10:0] cnt_inc;
    logic        blk_end;
    logic        last_k;
    logic        mul_start;
    logic        mul_done;
    logic signed [gmbd_pkg::MUL_PW-1:0] mul_p;
    logic signed [gmbd_pkg::MUL_AW-1:0] mul_a;
    logic signed [gmbd_pkg::MUL_BW-1:0] mul_b;
    logic signed [gmbd_pkg::COEF_W-1:0] cos_k;
    logic signed [XW-1:0] s0_w;
    logic signed [SW-1:0] s0_sat;

    always_comb
    begin
        len_eff = cfg.block_length;
        if (cfg.block_length == 11'd0)
            len_eff = 11'd1;
        else if (cfg.block_length > 11'(gmbd_pkg::MAX_BLOCK))
            len_eff = 11'(gmbd_pkg::MAX_BLOCK);
        tc_eff = (cfg.target_count > 3'(gmbd_pkg::MAX_TARGETS)) ?
                 3'(gmbd_pkg::MAX_TARGETS) : cfg.target_count;
    end

    assign cnt_inc = cnt_reg + 11'd1;
    assign blk_end = (cnt_inc >= len_eff);
    assign last_k  = ({1'b0, k_reg} + 3'd1 == tc_eff);
    assign cos_k   = $signed(cfg.coeff[k_reg][35:18]);
    assign mul_a   = {{(gmbd_pkg::MUL_AW-SW){s1_reg[k_reg][SW-1]}}, s1_reg[k_reg]};
    assign mul_b   = {cos_k, 1'b0};

    assign s0_w = $signed({{(XW-gmbd_pkg::SAMPLE_WIDTH){x_reg[gmbd_pkg::SAMPLE_WIDTH-1]}},
                           x_reg})
                + $signed({{(XW-gmbd_pkg::MUL_PW){mul_p[gmbd_pkg::MUL_PW-1]}}, mul_p})
                - $signed({{(XW-SW){s2_reg[k_reg][SW-1]}}, s2_reg[k_reg]});

    always_comb
    begin
        if (s0_w > ST_MAX)
            s0_sat = ST_MAX[SW-1:0];
        else if (s0_w < ST_MIN)
            s0_sat = ST_MIN[SW-1:0];
        else
            s0_sat = s0_w[SW-1:0];
    end

    gmbd_mulq16 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmbd_pkg::F_IDLE:
                if (sample_valid) state_next = gmbd_pkg::F_MUL;
            gmbd_pkg::F_MUL:
                state_next = gmbd_pkg::F_WAIT;
            gmbd_pkg::F_WAIT:
                if (mul_done)
                    state_next = (k_reg == 2'(gmbd_pkg::MAX_TARGETS - 1)) ?
                                 gmbd_pkg::F_END : gmbd_pkg::F_MUL;
            gmbd_pkg::F_END:
                if (blk_end && tc_eff != 3'd0)
                    state_next = gmbd_pkg::F_PUSH;
                else
                    state_next = gmbd_pkg::F_IDLE;
            gmbd_pkg::F_PUSH:
                if (!fifo_full && last_k) state_next = gmbd_pkg::F_IDLE;
            default:
                state_next = gmbd_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall   = 1'b1;
        mul_start      = 1'b0;
        push           = 1'b0;
        push_data.idx  = k_reg;
        push_data.s1   = s1_reg[k_reg];
        push_data.s2   = s2_reg[k_reg];
        push_data.last = last_k;
        case (state_reg)
            gmbd_pkg::F_IDLE: sample_stall = 1'b0;
            gmbd_pkg::F_MUL:  mul_start = 1'b1;
            gmbd_pkg::F_PUSH: push = !fifo_full;
            default:          sample_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmbd_pkg::F_IDLE;
            k_reg     <= 2'd0;
            cnt_reg   <= 11'd0;
            for (int i = 0; i < gmbd_pkg::MAX_TARGETS; i++)
            begin
                s1_reg[i] <= '0;
                s2_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                gmbd_pkg::F_IDLE:
                    k_reg <= 2'd0;
                gmbd_pkg::F_WAIT:
                    if (mul_done)
                    begin
                        s2_reg[k_reg] <= s1_reg[k_reg];
                        s1_reg[k_reg] <= s0_sat;
                        k_reg         <= k_reg + 2'd1;
                    end
                gmbd_pkg::F_END:
                begin
                    k_reg <= 2'd0;
                    if (!blk_end)
                        cnt_reg <= cnt_inc;
                    else if (tc_eff == 3'd0)
                    begin
                        cnt_reg <= 11'd0;
                        for (int i = 0; i < gmbd_pkg::MAX_TARGETS; i++)
                        begin
                            s1_reg[i] <= '0;
                            s2_reg[i] <= '0;
                        end
                    end
                end
                gmbd_pkg::F_PUSH:
                    if (!fifo_full)
                    begin
                        k_reg <= k_reg + 2'd1;
                        if (last_k)
                        begin
                            cnt_reg <= 11'd0;
                            for (int i = 0; i < gmbd_pkg::MAX_TARGETS; i++)
                            begin
                                s1_reg[i] <= '0;
                                s2_reg[i] <= '0;
                            end
                        end
                    end
                default:
                    k_reg <= k_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gmbd_pkg::F_IDLE && sample_valid)
            x_reg <= sample;
    end
endmodule
`default_nettype wire

[rtl/gmbd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmbd_back
// Per-bin DFT value, CORDIC vectoring and the registered result word.
// ----------------------------------------------------------------------------
module gmbd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gmbd_pkg::cfg_t   cfg,
    input  wire logic             fifo_empty,
    input  wire gmbd_pkg::entry_t fifo_data,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic [1:0]            target_index,
    output logic [25:0]           magnitude,
    output logic signed [15:0]    phase,
    output logic                  last_of_block
);
    localparam int AW = gmbd_pkg::MUL_AW;
    localparam int PW = gmbd_pkg::MUL_PW;
    localparam int SW = gmbd_pkg::ST_W;
    localparam int ZW = gmbd_pkg::Z_W;
    localparam logic signed [ZW-1:0] PI_Z = ZW'(gmbd_pkg::PI_Q16);
    localparam logic signed [ZW+1:0] PH_MAX = (ZW+2)'(gmbd_pkg::PHASE_MAX);
    localparam logic signed [PW-1:0] M_MAX  = PW'(gmbd_pkg::MAG_MAX);

    gmbd_pkg::back_state_t state_reg, state_next;
    gmbd_pkg::entry_t ent_reg;
    logic signed [AW-1:0] x_reg;
    logic signed [AW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [3:0]           i_reg;
    logic                 zero_reg;
    logic signed [PW-1:0] m_reg;
    logic                 rv_reg;
    logic [1:0]           idx_reg;
    logic [25:0]          mag_reg;
    logic signed [15:0]   ph_reg;
    logic                 last_reg;

    logic                 mul_start;
    logic                 mul_done;
    logic signed [AW-1:0] mul_a;
    logic signed [gmbd_pkg::MUL_BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW:0]   re_w;
    logic signed [AW-1:0] dx;
    logic signed [AW-1:0] dy;
    logic signed [ZW-1:0] at_w;
    logic signed [ZW+1:0] zr_w;
    logic signed [ZW+1:0] ph_w;
    logic signed [15:0]   ph_clamp;
    logic [25:0]          mag_clamp;
    logic                 out_free;

    assign out_free = !rv_reg || !result_stall;
    assign re_w = $signed({{(PW+1-SW){ent_reg.s1[SW-1]}}, ent_reg.s1})
                - $signed({mul_p[PW-1], mul_p});
    assign dx   = y_reg >>> i_reg;
    assign dy   = x_reg >>> i_reg;
    assign at_w = $signed({{(ZW-17){1'b0}}, gmbd_pkg::atan_q16(i_reg)});
    assign zr_w = $signed({{2{z_reg[ZW-1]}}, z_reg}) + (ZW+2)'(4);
    assign ph_w = zr_w >>> 3;

    always_comb
    begin
        if (ph_w > PH_MAX)
            ph_clamp = PH_MAX[15:0];
        else if (ph_w < -PH_MAX)
            ph_clamp = 16'(-PH_MAX);
        else
            ph_clamp = ph_w[15:0];
        if (m_reg[PW-1])
            mag_clamp = 26'd0;
        else if (m_reg > M_MAX)
            mag_clamp = M_MAX[25:0];
        else
            mag_clamp = m_reg[25:0];
    end

    gmbd_mulq16 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmbd_pkg::B_IDLE:  if (!fifo_empty) state_next = gmbd_pkg::B_RE;
            gmbd_pkg::B_RE:    state_next = gmbd_pkg::B_RE_W;
            gmbd_pkg::B_RE_W:  if (mul_done) state_next = gmbd_pkg::B_IM;
            gmbd_pkg::B_IM:    state_next = gmbd_pkg::B_IM_W;
            gmbd_pkg::B_IM_W:  if (mul_done) state_next = gmbd_pkg::B_PRE;
            gmbd_pkg::B_PRE:   state_next = gmbd_pkg::B_ROT;
            gmbd_pkg::B_ROT:
                if (i_reg == 4'(gmbd_pkg::CORDIC_STEPS - 1)) state_next = gmbd_pkg::B_MAG;
            gmbd_pkg::B_MAG:   state_next = gmbd_pkg::B_MAG_W;
            gmbd_pkg::B_MAG_W: if (mul_done) state_next = gmbd_pkg::B_FIN;
            gmbd_pkg::B_FIN:   if (out_free) state_next = gmbd_pkg::B_IDLE;
            default:           state_next = gmbd_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mul_start = 1'b0;
        mul_a     = {{(AW-SW){ent_reg.s2[SW-1]}}, ent_reg.s2};
        mul_b     = $signed({cfg.coeff[ent_reg.idx][35], cfg.coeff[ent_reg.idx][35:18]});
        case (state_reg)
            gmbd_pkg::B_IDLE: pop = !fifo_empty;
            gmbd_pkg::B_RE:   mul_start = 1'b1;
            gmbd_pkg::B_IM:
            begin
                mul_start = 1'b1;
                mul_b = $signed({cfg.coeff[ent_reg.idx][17], cfg.coeff[ent_reg.idx][17:0]});
            end
            gmbd_pkg::B_IM_W:
                mul_b = $signed({cfg.coeff[ent_reg.idx][17], cfg.coeff[ent_reg.idx][17:0]});
            gmbd_pkg::B_MAG:
            begin
                mul_start = 1'b1;
                mul_a     = x_reg;
                mul_b     = gmbd_pkg::MUL_BW'(gmbd_pkg::INV_GAIN_Q16);
            end
            gmbd_pkg::B_MAG_W:
            begin
                mul_a = x_reg;
                mul_b = gmbd_pkg::MUL_BW'(gmbd_pkg::INV_GAIN_Q16);
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmbd_pkg::B_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gmbd_pkg::B_FIN && out_free)
                rv_reg <= 1'b1;
            else if (!result_stall)
                rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            gmbd_pkg::B_IDLE:
                if (!fifo_empty) ent_reg <= fifo_data;
            gmbd_pkg::B_RE_W:
                if (mul_done) x_reg <= re_w[AW-1:0];
            gmbd_pkg::B_IM_W:
                if (mul_done) y_reg <= mul_p[AW-1:0];
            gmbd_pkg::B_PRE:
            begin
                zero_reg <= (x_reg == '0) && (y_reg == '0);
                i_reg    <= 4'd0;
                if (x_reg < 0)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= (y_reg >= 0) ? PI_Z : -PI_Z;
                end
                else
                    z_reg <= '0;
            end
            gmbd_pkg::B_ROT:
            begin
                i_reg <= i_reg + 4'd1;
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at_w;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at_w;
                end
            end
            gmbd_pkg::B_MAG_W:
                if (mul_done) m_reg <= mul_p;
            gmbd_pkg::B_FIN:
                if (out_free)
                begin
                    idx_reg  <= ent_reg.idx;
                    last_reg <= ent_reg.last;
                    mag_reg  <= zero_reg ? 26'd0 : mag_clamp;
                    ph_reg   <= zero_reg ? 16'sd0 : ph_clamp;
                end
            default:
                i_reg <= i_reg;
        endcase
    end

    assign result_valid  = rv_reg;
    assign target_index  = idx_reg;
    assign magnitude     = mag_reg;
    assign phase         = ph_reg;
    assign last_of_block = last_reg;
endmodule
`default_nettype wire

[dv/goertzel_multi_bin_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goertzel_multi_bin_detector_tb
// Drives sample blocks through the detector under several configurations and
// checks every per-bin magnitude/phase word against a cycle-free predictor.
// ----------------------------------------------------------------------------
module goertzel_multi_bin_detector_tb;

    localparam longint ST_HI = (64'sd1 <<< 47) - 1;
    localparam longint ST_LO = -ST_HI - 1;

    typedef struct {
        logic [1:0]         tidx;
        logic [25:0]        mag;
        logic signed [15:0] ph;
        logic               last;
    } bin_word_t;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         index;
        logic [35:0]        data;
        logic signed [15:0] smp;
    } job_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [35:0] cfg_data = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [15:0] sample = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [1:0] target_index;
    logic [25:0] magnitude;
    logic signed [15:0] phase;
    logic last_of_block;

    goertzel_multi_bin_detector dut (.*);

    // predictor state
    logic [10:0] blk_len;
    logic [2:0]  n_targets;
    logic [35:0] coeff [gmbd_pkg::MAX_TARGETS];
    longint      s_prev [gmbd_pkg::MAX_TARGETS];
    longint      s_prev2 [gmbd_pkg::MAX_TARGETS];
    int          n_seen;

    bin_word_t bins_due[$];
    job_t      jobs[$];
    int        fails = 0;
    bit        stim_done = 1'b0;
    bit        in_acc = 1'b0;
    bit        cfg_acc = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_q16(longint a, longint c);
        longint hi, lo;
        hi = a >>> 16;
        lo = a - hi * 65536;
        return c * hi + ((c * lo + 32768) >>> 16);
    endfunction

    function automatic longint cos_of(logic [35:0] w);
        return longint'($signed(w[35:18]));
    endfunction

    function automatic longint sin_of(logic [35:0] w);
        return longint'($signed(w[17:0]));
    endfunction

    function automatic void vector_to_polar(longint re, longint im,
                                            output logic [25:0] mag,
                                            output logic signed [15:0] ph);
        longint x, y, z, dx, dy, m, p;
        longint atans [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
        x = re;
        y = im;
        z = 0;
        if (re == 0 && im == 0)
        begin
            mag = '0;
            ph = '0;
            return;
        end
        if (x < 0)
        begin
            z = (im >= 0) ? gmbd_pkg::PI_Q16 : -gmbd_pkg::PI_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atans[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atans[i];
            end
        end
        m = round_q16(x, gmbd_pkg::INV_GAIN_Q16);
        if (m < 0) m = 0;
        if (m > gmbd_pkg::MAG_MAX) m = gmbd_pkg::MAG_MAX;
        p = (z + 4) >>> 3;
        if (p > gmbd_pkg::PHASE_MAX) p = gmbd_pkg::PHASE_MAX;
        if (p < -gmbd_pkg::PHASE_MAX) p = -gmbd_pkg::PHASE_MAX;
        mag = m[25:0];
        ph = p[15:0];
    endfunction

    function automatic void reset_bins();
        for (int k = 0; k < gmbd_pkg::MAX_TARGETS; k++)
        begin
            s_prev[k] = 0;
            s_prev2[k] = 0;
        end
        n_seen = 0;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [35:0] d);
        case (idx)
            gmbd_pkg::CFG_BLOCK_LENGTH: blk_len = d[10:0];
            gmbd_pkg::CFG_TARGET_COUNT: n_targets = d[2:0];
            gmbd_pkg::CFG_COEFF_0:      coeff[0] = d;
            gmbd_pkg::CFG_COEFF_1:      coeff[1] = d;
            gmbd_pkg::CFG_COEFF_2:      coeff[2] = d;
            gmbd_pkg::CFG_COEFF_3:      coeff[3] = d;
            default: ;
        endcase
    endfunction

    function automatic void predict_sample(logic signed [15:0] smp);
        longint s0, c, re, im;
        int len, cnt;
        bin_word_t w;
        for (int k = 0; k < gmbd_pkg::MAX_TARGETS; k++)
        begin
            c = cos_of(coeff[k]);
            s0 = longint'(smp) + round_q16(s_prev[k], 2 * c) - s_prev2[k];
            if (s0 > ST_HI) s0 = ST_HI;
            if (s0 < ST_LO) s0 = ST_LO;
            s_prev2[k] = s_prev[k];
            s_prev[k] = s0;
        end
        len = blk_len;
        if (len == 0) len = 1;
        if (len > gmbd_pkg::MAX_BLOCK) len = gmbd_pkg::MAX_BLOCK;
        n_seen = (n_seen + 1) & 11'h7ff;
        if (n_seen < len) return;
        cnt = n_targets;
        if (cnt > gmbd_pkg::MAX_TARGETS) cnt = gmbd_pkg::MAX_TARGETS;
        for (int k = 0; k < cnt; k++)
        begin
            re = s_prev[k] - round_q16(s_prev2[k], cos_of(coeff[k]));
            im = round_q16(s_prev2[k], sin_of(coeff[k]));
            w.tidx = k[1:0];
            vector_to_polar(re, im, w.mag, w.ph);
            w.last = (k + 1 == cnt);
            bins_due.push_back(w);
        end
        reset_bins();
    endfunction

    initial
    begin
        forever #2 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        logic cv_n;
        logic sv_n;
        if (rst_n)
        begin
            cv_n = cfg_valid && !cfg_acc;
            sv_n = sample_valid && !in_acc;
            if (!cv_n && !sv_n)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (jobs.size() > 0)
                begin
                    if (jobs[0].is_cfg)
                    begin
                        // registers change only with nothing in flight
                        if (!sample_stall && bins_due.size() == 0)
                        begin
                            cfg_index <= jobs[0].index;
                            cfg_data <= jobs[0].data;
                            cv_n = 1'b1;
                            void'(jobs.pop_front());
                        end
                    end
                    else if (jobs[0].index == 3'b111)
                    begin
                        // pause marker: hold until every result is in
                        if (bins_due.size() == 0)
                        begin
                            if (jobs[0].data == 0) void'(jobs.pop_front());
                            else jobs[0].data--;
                        end
                    end
                    else
                    begin
                        sample <= jobs[0].smp;
                        sv_n = 1'b1;
                        void'(jobs.pop_front());
                        if (burst_left > 0)
                        begin
                            burst_left--;
                        end
                        else
                        begin
                            burst_left = $urandom_range(0, 12);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                        end
                    end
                end
                else
                begin
                    stim_done = 1'b1;
                end
            end
            cfg_valid <= cv_n;
            sample_valid <= sv_n;
            case ($urandom_range(0, 3))
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 2) == 0);
                default: result_stall <= result_stall ^ ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        bin_word_t w;
        in_acc = rst_n && sample_valid && !sample_stall;
        cfg_acc = rst_n && cfg_valid && cfg_ready;
        if (cfg_acc) apply_cfg(cfg_index, cfg_data);
        if (in_acc) predict_sample(sample);
        if (rst_n && result_valid && !result_stall)
        begin
            if (bins_due.size() == 0)
            begin
                $error("unexpected word: target_index %0d", target_index);
                fails++;
            end
            else
            begin
                w = bins_due.pop_front();
                if (target_index !== w.tidx)
                begin
                    $error("target_index exp %0d got %0d", w.tidx, target_index);
                    fails++;
                end
                if (magnitude !== w.mag)
                begin
                    $error("magnitude exp %0d got %0d", w.mag, magnitude);
                    fails++;
                end
                if (phase !== w.ph)
                begin
                    $error("phase exp %0d got %0d", w.ph, phase);
                    fails++;
                end
                if (last_of_block !== w.last)
                begin
                    $error("last_of_block exp %0d got %0d", w.last, last_of_block);
                    fails++;
                end
            end
        end
    end

    function automatic void push_cfg(logic [2:0] idx, logic [35:0] d);
        job_t j;
        j.is_cfg = 1'b1;
        j.index = idx;
        j.data = d;
        j.smp = '0;
        jobs.push_back(j);
    endfunction

    function automatic void push_smp(logic signed [15:0] s);
        job_t j;
        j.is_cfg = 1'b0;
        j.index = '0;
        j.data = '0;
        j.smp = s;
        jobs.push_back(j);
    endfunction

    // drain, then idle long enough for the result unit to finish a block
    function automatic void push_quiesce();
        job_t j;
        j.is_cfg = 1'b0;
        j.index = 3'b111;
        j.data = 36'd200;
        j.smp = '0;
        jobs.push_back(j);
    endfunction

    function automatic logic [35:0] tone_coeff(real w);
        int c, s;
        c = $rtoi($floor($cos(w) * 65536.0 + 0.5));
        s = $rtoi($floor($sin(w) * 65536.0 + 0.5));
        return {c[17:0], s[17:0]};
    endfunction

    function automatic logic [35:0] rand_coeff();
        case ($urandom_range(0, 3))
            0:       return 36'({$urandom(), $urandom()});
            1:       return tone_coeff(3.14159265 * $urandom_range(0, 1000) / 1000.0);
            2:       return {18'h1ffff, 18'h20000};
            default: return {18'h20000, 18'h1ffff};
        endcase
    endfunction

    function automatic logic signed [15:0] rand_sample(int k, real w);
        case ($urandom_range(0, 4))
            0:       return 16'($urandom());
            1:       return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return 16'($rtoi(20000.0 * $sin(w * k)));
        endcase
    endfunction

    initial
    begin
        int len, tot, nsmp;
        real w;
        blk_len = 11'd256;
        n_targets = '0;
        for (int k = 0; k < gmbd_pkg::MAX_TARGETS; k++) coeff[k] = '0;
        reset_bins();

        // directed: extremes, zero targets, oversize count, mid-block length drop
        push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'd1);
        push_smp(16'sh7fff);
        push_cfg(gmbd_pkg::CFG_TARGET_COUNT, 36'd7);
        push_cfg(gmbd_pkg::CFG_COEFF_0, {18'h1ffff, 18'h1ffff});
        push_cfg(gmbd_pkg::CFG_COEFF_1, {18'h20000, 18'h20000});
        push_cfg(gmbd_pkg::CFG_COEFF_2, tone_coeff(0.5));
        push_cfg(gmbd_pkg::CFG_COEFF_3, 36'd0);
        push_smp(16'sh8000);
        push_smp(16'sh0000);
        push_smp(16'sh7fff);
        push_quiesce();
        push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'd0);
        push_smp(-16'sd1);
        push_quiesce();
        push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'h7ff);
        push_cfg(gmbd_pkg::CFG_TARGET_COUNT, 36'd4);
        push_cfg(gmbd_pkg::CFG_COEFF_0, {18'h1ffff, 18'h00000});
        push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'd3);
        for (int i = 0; i < 6; i++) push_smp((i % 2) ? 16'sh8000 : 16'sh7fff);
        push_quiesce();
        push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'd5);
        for (int i = 0; i < 2; i++) push_smp(16'sh1234);
        push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'd2);
        push_smp(16'sh5555);
        push_quiesce();

        tot = 14;
        while (tot < 170)
        begin
            push_cfg(gmbd_pkg::CFG_TARGET_COUNT, 36'($urandom_range(0, 7)));
            for (int k = 0; k < gmbd_pkg::MAX_TARGETS; k++)
                if ($urandom_range(0, 1))
                    push_cfg(3'(gmbd_pkg::CFG_COEFF_0 + k), rand_coeff());
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            push_cfg(gmbd_pkg::CFG_BLOCK_LENGTH, 36'(len));
            if (len == 0) len = 1;
            nsmp = len * $urandom_range(1, 2);
            w = 3.14159265 * $urandom_range(0, 1000) / 1000.0;
            for (int i = 0; i < nsmp; i++)
                push_smp(rand_sample(i, w));
            tot += nsmp;
            push_quiesce();
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done);
        wait (bins_due.size() == 0);
        repeat (300) @(posedge clk);
        if (fails == 0 && bins_due.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
rtl/gmbd_pkg.sv
rtl/gmbd_mulq16.sv
rtl/gmbd_fifo.sv
rtl/gmbd_front.sv
rtl/gmbd_back.sv
rtl/goertzel_multi_bin_detector.sv
dv/goertzel_multi_bin_detector_tb.sv
